/* sv/vfc_pkg.sv */
package vfc_pkg;

	localparam int MAX_DIM  = 16;
	localparam int COORD_W  = $clog2(MAX_DIM);
	localparam int SIZE_W   = 5;
	localparam int ADDR_W   = 3 * COORD_W;
	localparam int KIND_W   = 8;
	localparam int CELL_W   = KIND_W + 1;
	localparam int VTX_W    = 17;
	localparam int DIR_W    = 3;
	localparam int NUM_DIRS = 6;
	localparam int SEL_W    = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [VTX_W-1:0] VTX_STEP = VTX_W'(4);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	// request opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// read sequence: center cell first, then one read per side
	localparam logic [SEL_W-1:0] RD_CENTER = 3'd0;
	localparam logic [SEL_W-1:0] RD_LAST   = 3'd6;
	localparam logic [SEL_W-1:0] RD_END    = 3'd7;

	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [COORD_W-1:0] cell_z;
		logic               is_transparent;
		logic [KIND_W-1:0]  block_kind;
	} in_t;

	typedef struct packed {
		logic [COORD_W-1:0] face_x;
		logic [COORD_W-1:0] face_y;
		logic [COORD_W-1:0] face_z;
		logic [DIR_W-1:0]   face_dir;
		logic [VTX_W-1:0]   first_vertex;
		logic [KIND_W-1:0]  face_kind;
		logic               face_valid;
		logic               last_of_cell;
		logic               mesh_done;
	} out_t;

	typedef struct packed {
		logic             wr_en;
		logic             rd_en;
		logic [SEL_W-1:0] rd_sel;
		logic             cap_en;
		logic [SEL_W-1:0] cap_sel;
		logic             emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_rec;
	} stat_t;

endpackage

/* sv/voxel_face_cull_mesher.sv */
// channel | signals                        | direction | contents
// in      | in_valid, in_ready, in_data    | input     | cell write or mesh step request
// out     | out_valid, out_ready, out_data | output    | face record, one to six per step
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | input | size_x, size_y, size_z
//
// a cell write goes to the store as it is taken; a mesh step makes seven reads
// through the cell store's one read port (cell and six sides), waits for the last
// read data, then moves one record per cycle into the output register.
// a stalled output holds the emit sequence; no new request is taken until the
// last record of a step is in the output register. reset clears cursor and
// vertex counter; the cell store is not cleared. cfg writes are always taken.
module voxel_face_cull_mesher (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  vfc_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output vfc_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vfc_pkg::SIZE_W-1:0]    cfg_data
);

	vfc_pkg::cmd_t  cmd;
	vfc_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	vfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.op),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	vfc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* sv/vfc_ram.sv */
module vfc_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* sv/vfc_ctrl.sv */
module vfc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_op,
	output logic           in_ready,
	output vfc_pkg::cmd_t  cmd,
	input  vfc_pkg::stat_t stat
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                state_q;
	logic [vfc_pkg::SEL_W-1:0] cnt_q;
	logic                      accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd         = '0;
		cmd.wr_en   = accept && (in_op == vfc_pkg::OP_WRITE);
		cmd.rd_sel  = cnt_q;
		cmd.cap_sel = cnt_q - vfc_pkg::SEL_W'(1);
		if (state_q == ST_READ) begin
			cmd.rd_en  = (cnt_q <= vfc_pkg::RD_LAST);
			cmd.cap_en = (cnt_q != vfc_pkg::RD_CENTER);
		end
		cmd.emit = (state_q == ST_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= vfc_pkg::RD_CENTER;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= vfc_pkg::RD_CENTER;
					if (accept && in_op == vfc_pkg::OP_STEP)
						state_q <= ST_READ;
				end
				ST_READ: begin
					cnt_q <= cnt_q + vfc_pkg::SEL_W'(1);
					if (cnt_q == vfc_pkg::RD_END)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.emit && stat.last_rec)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/vfc_dp.sv */
module vfc_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vfc_pkg::in_t                    in_data,
	input  logic                            cfg_valid,
	input  logic [vfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vfc_pkg::SIZE_W-1:0]      cfg_data,
	input  vfc_pkg::cmd_t                   cmd,
	output vfc_pkg::stat_t                  stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output vfc_pkg::out_t                   out_data
);

	localparam int CW = vfc_pkg::COORD_W;
	localparam int SW = vfc_pkg::SIZE_W;
	localparam int ND = vfc_pkg::NUM_DIRS;

	function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] s);
		if (s == '0)
			return SW'(1);
		else if (s > SW'(vfc_pkg::MAX_DIM))
			return SW'(vfc_pkg::MAX_DIM);
		else
			return s;
	endfunction

	logic [SW-1:0] size_x_q, size_y_q, size_z_q;
	logic [SW-1:0] sx, sy, sz;

	logic [CW-1:0]               cx_q, cy_q, cz_q;
	logic [vfc_pkg::VTX_W-1:0]   vcnt_q;
	logic [vfc_pkg::KIND_W-1:0]  kind_q;
	logic                        solid_q;
	logic [ND-1:0]               trans_q;
	logic [ND-1:0]               done_q;
	logic                        out_valid_q;
	vfc_pkg::out_t               out_q;

	logic [SW-1:0] cx5, cy5, cz5;
	logic [SW-1:0] nbx [ND];
	logic [SW-1:0] nby [ND];
	logic [SW-1:0] nbz [ND];
	logic [vfc_pkg::ADDR_W-1:0] rd_addr [8];
	logic [ND-1:0] oor;
	logic [ND-1:0] faces, rem, lowbit;
	logic [vfc_pkg::DIR_W-1:0] low_dir;
	logic last_rec, pass_end, wr_ok;
	logic [vfc_pkg::CELL_W-1:0] rdata;

	assign sx = eff_size(size_x_q);
	assign sy = eff_size(size_y_q);
	assign sz = eff_size(size_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SW'(vfc_pkg::MAX_DIM);
			size_y_q <= SW'(vfc_pkg::MAX_DIM);
			size_z_q <= SW'(vfc_pkg::MAX_DIM);
		end else if (cfg_valid) begin
			if (cfg_index == vfc_pkg::REG_SIZE_X)
				size_x_q <= cfg_data;
			else if (cfg_index == vfc_pkg::REG_SIZE_Y)
				size_y_q <= cfg_data;
			else if (cfg_index == vfc_pkg::REG_SIZE_Z)
				size_z_q <= cfg_data;
		end
	end

	// cell write, dropped outside the active grid
	assign wr_ok = cmd.wr_en
		&& ({1'b0, in_data.cell_x} < sx)
		&& ({1'b0, in_data.cell_y} < sy)
		&& ({1'b0, in_data.cell_z} < sz);

	// neighbor coordinates; -1 wraps to all ones and so falls outside the grid
	assign cx5 = {1'b0, cx_q};
	assign cy5 = {1'b0, cy_q};
	assign cz5 = {1'b0, cz_q};

	always_comb begin
		for (int d = 0; d < ND; d++) begin
			nbx[d] = cx5;
			nby[d] = cy5;
			nbz[d] = cz5;
		end
		nbx[0] = cx5 - SW'(1);
		nbx[1] = cx5 + SW'(1);
		nby[2] = cy5 - SW'(1);
		nby[3] = cy5 + SW'(1);
		nbz[4] = cz5 - SW'(1);
		nbz[5] = cz5 + SW'(1);
		rd_addr[0] = {cx_q, cy_q, cz_q};
		rd_addr[7] = {cx_q, cy_q, cz_q};
		for (int d = 0; d < ND; d++) begin
			oor[d] = (nbx[d] >= sx) || (nby[d] >= sy) || (nbz[d] >= sz);
			rd_addr[d+1] = {nbx[d][CW-1:0], nby[d][CW-1:0], nbz[d][CW-1:0]};
		end
	end

	vfc_ram #(
		.ADDR_W(vfc_pkg::ADDR_W),
		.DATA_W(vfc_pkg::CELL_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_ok),
		.waddr ({in_data.cell_x, in_data.cell_y, in_data.cell_z}),
		.wdata ({in_data.is_transparent, in_data.block_kind}),
		.re    (cmd.rd_en),
		.raddr (rd_addr[cmd.rd_sel]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			if (cmd.cap_sel == vfc_pkg::RD_CENTER) begin
				kind_q  <= rdata[vfc_pkg::KIND_W-1:0];
				solid_q <= ~rdata[vfc_pkg::KIND_W];
			end
			for (int d = 0; d < ND; d++) begin
				if (cmd.cap_sel == vfc_pkg::SEL_W'(d + 1))
					trans_q[d] <= rdata[vfc_pkg::KIND_W];
			end
		end
	end

	// pick the lowest side still to be emitted
	assign faces  = solid_q ? (oor | trans_q) : '0;
	assign rem    = faces & ~done_q;
	assign lowbit = rem & (~rem + ND'(1));

	always_comb begin
		low_dir = '0;
		for (int d = ND - 1; d >= 0; d--) begin
			if (rem[d])
				low_dir = vfc_pkg::DIR_W'(d);
		end
	end

	assign last_rec = (rem & ~lowbit) == '0;
	assign pass_end = (cx5 + SW'(1) >= sx) && (cy5 + SW'(1) >= sy) && (cz5 + SW'(1) >= sz);

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.last_rec = last_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			cz_q        <= '0;
			vcnt_q      <= '0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (cmd.emit) begin
				if (last_rec)
					done_q <= '0;
				else
					done_q <= done_q | lowbit;

				if (last_rec && pass_end)
					vcnt_q <= '0;
				else if (rem != '0)
					vcnt_q <= vcnt_q + vfc_pkg::VTX_STEP;

				// x-major cursor walk, z innermost
				if (last_rec) begin
					if (cz5 + SW'(1) < sz) begin
						cz_q <= cz_q + CW'(1);
					end else begin
						cz_q <= '0;
						if (cy5 + SW'(1) < sy) begin
							cy_q <= cy_q + CW'(1);
						end else begin
							cy_q <= '0;
							if (cx5 + SW'(1) < sx)
								cx_q <= cx_q + CW'(1);
							else
								cx_q <= '0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.face_x       <= cx_q;
			out_q.face_y       <= cy_q;
			out_q.face_z       <= cz_q;
			out_q.face_dir     <= low_dir;
			out_q.first_vertex <= vcnt_q;
			out_q.face_kind    <= kind_q;
			out_q.face_valid   <= (rem != '0);
			out_q.last_of_cell <= last_rec;
			out_q.mesh_done    <= pass_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* bench/voxel_face_cull_mesher_test.sv */
module voxel_face_cull_mesher_test;
	import vfc_pkg::*;

	typedef enum logic [DIR_W-1:0] {
		SIDE_NEG_X, SIDE_POS_X, SIDE_NEG_Y, SIDE_POS_Y, SIDE_NEG_Z, SIDE_POS_Z
	} side_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int GRID_CELLS = MAX_DIM * MAX_DIM * MAX_DIM;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_data;

	// mirror of the block state
	logic [CELL_W-1:0] grid_cells [GRID_CELLS];
	bit                grid_written [GRID_CELLS];
	logic [SIZE_W-1:0] size_reg [3];
	int                cur_x, cur_y, cur_z;
	logic [VTX_W-1:0]  vtx_count;

	out_t face_q [$];
	out_t want_rec;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int fail_count;
	int requests_done;
	int records_checked;
	int passes_done;

	voxel_face_cull_mesher i_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int eff_size(logic [SIZE_W-1:0] s);
		if (s == 0) return 1;
		if (s > MAX_DIM) return MAX_DIM;
		return int'(s);
	endfunction

	function automatic int cell_addr(int x, int y, int z);
		return (x * MAX_DIM + y) * MAX_DIM + z;
	endfunction

	function automatic bit side_exposed(int x, int y, int z);
		if (x < 0 || y < 0 || z < 0) return 1'b1;
		if (x >= eff_size(size_reg[REG_SIZE_X]) || y >= eff_size(size_reg[REG_SIZE_Y]) ||
				z >= eff_size(size_reg[REG_SIZE_Z])) return 1'b1;
		return grid_cells[cell_addr(x, y, z)][KIND_W];
	endfunction

	function automatic void reset_grid_state();
		foreach (grid_cells[i]) begin
			grid_cells[i] = '0;
			grid_written[i] = 1'b0;
		end
		foreach (size_reg[i]) size_reg[i] = SIZE_W'(MAX_DIM);
		cur_x = 0;
		cur_y = 0;
		cur_z = 0;
		vtx_count = '0;
	endfunction

	function automatic void predict_faces(in_t req);
		out_t              rec;
		out_t              recs [$];
		logic [CELL_W-1:0] cur_cell;
		int                sx, sy, sz, nx, ny, nz;
		bit                wrapped;
		sx = eff_size(size_reg[REG_SIZE_X]);
		sy = eff_size(size_reg[REG_SIZE_Y]);
		sz = eff_size(size_reg[REG_SIZE_Z]);
		requests_done++;
		if (req.op == OP_WRITE) begin
			if (req.cell_x < sx && req.cell_y < sy && req.cell_z < sz) begin
				grid_cells[cell_addr(req.cell_x, req.cell_y, req.cell_z)] =
					{req.is_transparent, req.block_kind};
				grid_written[cell_addr(req.cell_x, req.cell_y, req.cell_z)] = 1'b1;
			end
			return;
		end
		cur_cell = grid_cells[cell_addr(cur_x, cur_y, cur_z)];
		rec = '0;
		rec.face_x = COORD_W'(cur_x);
		rec.face_y = COORD_W'(cur_y);
		rec.face_z = COORD_W'(cur_z);
		rec.face_kind = cur_cell[KIND_W-1:0];
		if (!cur_cell[KIND_W]) begin
			for (int d = 0; d < NUM_DIRS; d++) begin
				nx = cur_x + int'(d == SIDE_POS_X) - int'(d == SIDE_NEG_X);
				ny = cur_y + int'(d == SIDE_POS_Y) - int'(d == SIDE_NEG_Y);
				nz = cur_z + int'(d == SIDE_POS_Z) - int'(d == SIDE_NEG_Z);
				if (side_exposed(nx, ny, nz)) begin
					rec.face_dir = DIR_W'(d);
					rec.first_vertex = vtx_count;
					rec.face_valid = 1'b1;
					recs.insert(recs.size(), rec);
					vtx_count += VTX_STEP;
				end
			end
		end
		// transparent or fully hidden cell still gives one blank record
		if (recs.size() == 0) begin
			rec.face_dir = SIDE_NEG_X;
			rec.first_vertex = vtx_count;
			rec.face_valid = 1'b0;
			recs.insert(recs.size(), rec);
		end
		// a coordinate at or past its size counts as the last one
		wrapped = 1'b0;
		if (cur_z + 1 < sz) begin
			cur_z++;
		end else begin
			cur_z = 0;
			if (cur_y + 1 < sy) begin
				cur_y++;
			end else begin
				cur_y = 0;
				if (cur_x + 1 < sx) begin
					cur_x++;
				end else begin
					cur_x = 0;
					wrapped = 1'b1;
				end
			end
		end
		recs[recs.size() - 1].last_of_cell = 1'b1;
		foreach (recs[i]) begin
			recs[i].mesh_done = wrapped;
			face_q.insert(face_q.size(), recs[i]);
		end
		if (wrapped) vtx_count = '0;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (face_q.size() == 0) begin
				$error("face record with none expected: %p", out_data);
				fail_count++;
			end else begin
				want_rec = face_q.pop_front();
				check_field("face_x", want_rec.face_x, out_data.face_x);
				check_field("face_y", want_rec.face_y, out_data.face_y);
				check_field("face_z", want_rec.face_z, out_data.face_z);
				check_field("face_dir", want_rec.face_dir, out_data.face_dir);
				check_field("first_vertex", want_rec.first_vertex, out_data.first_vertex);
				check_field("face_kind", want_rec.face_kind, out_data.face_kind);
				check_field("face_valid", want_rec.face_valid, out_data.face_valid);
				check_field("last_of_cell", want_rec.last_of_cell, out_data.last_of_cell);
				check_field("mesh_done", want_rec.mesh_done, out_data.mesh_done);
				records_checked++;
				if (want_rec.mesh_done && want_rec.last_of_cell) passes_done++;
			end
		end
	end

	// receiver: random stalls, or a long hold when one is requested
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic set_idle_mode(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 66;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 66;
			end
			default: begin
				send_idle_pct = 9;
				recv_stall_pct = 9;
			end
		endcase
	endtask

	task automatic send_request(in_t req);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_faces(req);
	endtask

	task automatic write_cell(int x, int y, int z, bit transparent, logic [KIND_W-1:0] kind);
		in_t req;
		req.op = OP_WRITE;
		req.cell_x = COORD_W'(x);
		req.cell_y = COORD_W'(y);
		req.cell_z = COORD_W'(z);
		req.is_transparent = transparent;
		req.block_kind = kind;
		send_request(req);
	endtask

	task automatic mesh_step();
		in_t req;
		// coordinate and content fields carry noise on a step
		req = in_t'($urandom);
		req.op = OP_STEP;
		send_request(req);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (face_q.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx <= REG_SIZE_Z) size_reg[idx] = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
			logic [SIZE_W-1:0] sz);
		wait_idle();
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_Z, sz);
	endtask

	// every cell a step can touch must hold data before the pass reads it
	task automatic fill_grid(int trans_pct);
		int ex, ey, ez;
		ex = eff_size(size_reg[REG_SIZE_X]);
		ey = eff_size(size_reg[REG_SIZE_Y]);
		ez = eff_size(size_reg[REG_SIZE_Z]);
		for (int x = 0; x < ex; x++)
			for (int y = 0; y < ey; y++)
				for (int z = 0; z < ez; z++)
					if (!grid_written[cell_addr(x, y, z)])
						write_cell(x, y, z, $urandom_range(99) < trans_pct, KIND_W'($urandom));
	endtask

	task automatic test_reset_writes();
		write_cell(0, 0, 0, 1'b0, 8'h00);
		write_cell(15, 15, 15, 1'b1, 8'hFF);
	endtask

	task automatic test_single_cell();
		configure(5'd1, 5'd1, 5'd1);
		mesh_step();
		write_cell(0, 0, 0, 1'b1, 8'hA5);
		mesh_step();
		// writes past the active sizes leave the store alone
		write_cell(1, 0, 0, 1'b0, 8'hFF);
		write_cell(0, 15, 0, 1'b0, 8'hFF);
		write_cell(0, 0, 15, 1'b0, 8'hFF);
		mesh_step();
	endtask

	task automatic test_size_extremes();
		configure(5'd0, 5'd0, 5'd2);
		write_reg(REG_UNUSED, '1);
		write_cell(0, 0, 1, 1'b0, 8'hFF);
		mesh_step();
		mesh_step();
	endtask

	task automatic test_hidden_cell();
		configure(5'd3, 5'd3, 5'd3);
		for (int x = 0; x < 3; x++)
			for (int y = 0; y < 3; y++)
				for (int z = 0; z < 3; z++)
					write_cell(x, y, z, 1'b0, KIND_W'($urandom));
		// center cell is the fourteenth visited
		repeat (14) mesh_step();
		// shrink with the cursor mid pass, it now sits past every size
		configure(5'd1, 5'd1, 5'd1);
		mesh_step();
	endtask

	task automatic test_random_passes(int items);
		int                goal, phase, cells_n, ex, ey, ez, trans_pct, pick, x, y, z;
		logic [SIZE_W-1:0] dims [3];
		goal = requests_done + items;
		phase = 0;
		while (requests_done < goal) begin
			if ($urandom_range(99) < 20) begin
				pick = $urandom_range(2);
				foreach (dims[i])
					dims[i] = (i == pick) ? ($urandom_range(1) ? 5'd16 : 5'd31) :
						SIZE_W'($urandom_range(2));
			end else begin
				foreach (dims[i]) dims[i] = SIZE_W'($urandom_range(4));
			end
			set_idle_mode(idle_mode_t'(phase % 4));
			configure(dims[0], dims[1], dims[2]);
			ex = eff_size(size_reg[REG_SIZE_X]);
			ey = eff_size(size_reg[REG_SIZE_Y]);
			ez = eff_size(size_reg[REG_SIZE_Z]);
			trans_pct = $urandom_range(5, 60);
			fill_grid(trans_pct);
			cells_n = ex * ey * ez;
			repeat (cells_n + $urandom_range(cells_n)) begin
				pick = $urandom_range(99);
				if (pick < 20) begin
					write_cell($urandom_range(ex - 1), $urandom_range(ey - 1),
						$urandom_range(ez - 1), $urandom_range(99) < trans_pct,
						KIND_W'($urandom));
				end else if (pick < 26 && cells_n < GRID_CELLS) begin
					do begin
						x = $urandom_range(MAX_DIM - 1);
						y = $urandom_range(MAX_DIM - 1);
						z = $urandom_range(MAX_DIM - 1);
					end while (x < ex && y < ey && z < ez);
					write_cell(x, y, z, $urandom_range(1), KIND_W'($urandom));
				end else begin
					mesh_step();
				end
			end
			phase++;
		end
	endtask

	task automatic test_output_backpressure();
		set_idle_mode(IDLE_NONE);
		fill_grid(30);
		wait_idle();
		hold_cycles = 200;
		repeat (12) mesh_step();
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SIZE_X;
		cfg_data = '0;
		hold_cycles = 0;
		fail_count = 0;
		requests_done = 0;
		records_checked = 0;
		passes_done = 0;
		reset_grid_state();
		set_idle_mode(IDLE_NONE);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_writes();
		test_single_cell();
		test_size_extremes();
		test_hidden_cell();
		test_random_passes(400);
		test_output_backpressure();
		wait_idle();

		$display("%0d requests taken, %0d face records checked, %0d mesh passes finished",
			requests_done, records_checked, passes_done);
		$display("grid sizes 0 to 31 per axis, shrink mid pass, long output hold, mixed stalls");
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/vfc_pkg.sv
sv/vfc_ram.sv
sv/vfc_ctrl.sv
sv/vfc_dp.sv
sv/voxel_face_cull_mesher.sv
bench/voxel_face_cull_mesher_test.sv
